FILE: src/dfr_pkg.sv
// shared types and constants of the delimited frame receiver
// used by dfr_cmp, dfr_linebuf and the top level; depends on nothing
package dfr_pkg;

  localparam int unsigned ByteW = 8;

  // frame checks
  localparam logic [ByteW-1:0] DelimReset  = 8'd126;
  localparam logic [ByteW-1:0] MinFrameLen = 8'd8;   // shortest frame that is not dropped as short
  localparam logic [ByteW-1:0] BcastMinLen = 8'd50;
  localparam logic [ByteW-1:0] BcastValA   = 8'hFF;
  localparam logic [ByteW-1:0] BcastValB   = 8'h02;

  // fixed buffer positions that the frame checks look at
  localparam int unsigned PosHead   = 0;
  localparam int unsigned PosBcastA = 31;
  localparam int unsigned PosBcastB = 32;
  localparam int unsigned PosGroupL = 45;
  localparam int unsigned PosGroupH = 46;

  localparam int unsigned LenW  = 7;
  localparam int unsigned GroupW = 16;

  typedef struct packed {
    logic [ByteW-1:0] head;
    logic [ByteW-1:0] bcast_a;
    logic [ByteW-1:0] bcast_b;
    logic [ByteW-1:0] group_l;
    logic [ByteW-1:0] group_h;
  } taps_t;

endpackage

FILE: src/delimited_frame_receiver.sv
// top level of the delimited frame receiver: check sequencer, output register
// depends on dfr_pkg, dfr_cmp and dfr_linebuf

// Each accepted byte within capacity is stored in the line buffer and then checked by one
// shared byte comparator stepping under a small sequencer. Every byte, also a delimiter that
// opens a frame, is compared with the delimiter before the next is taken. A closing delimiter
// runs the length, head and broadcast checks one per cycle, and a frame that passes is then
// read out of the single buffer read port a byte at a time, each read registered before it
// is loaded into the output register, which waits while the output is stalled; the input is
// not ready until the whole frame is out. The buffer needs no clearing: every position read
// out was written after the last reset or frame end.
module delimited_frame_receiver #(
  parameter int unsigned FRAME_CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,       // delimiter_byte
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,    // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,    // [7:0] frame_byte, [14:8] frame_length,
                                         // [30:15] group_address, [31] zero
  output logic        m_axis_tlast_o,    // last_byte
  output logic        m_axis_tuser_o     // is_broadcast
);

  localparam int unsigned AddrW = $clog2(FRAME_CAPACITY);
  localparam int unsigned PosW  = $clog2(FRAME_CAPACITY + 1);
  localparam int unsigned BW    = dfr_pkg::ByteW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DELIM  = 4'd1;
  localparam logic [3:0] S_LEN    = 4'd2;
  localparam logic [3:0] S_HEAD   = 4'd3;
  localparam logic [3:0] S_BLEN   = 4'd4;
  localparam logic [3:0] S_BA     = 4'd5;
  localparam logic [3:0] S_BB     = 4'd6;
  localparam logic [3:0] S_EMITRD = 4'd7;
  localparam logic [3:0] S_EMITLD = 4'd8;

  logic [3:0]              state_q, state_d;
  logic [PosW-1:0]         wp_q, wp_d;
  logic [1:0]              cnt_q, cnt_d;
  logic [BW-1:0]           byte_q, byte_d;
  logic [BW-1:0]           delim_q;
  logic                    flag_q, flag_d;
  logic [PosW-1:0]         len_q, len_d;
  logic                    bcast_q, bcast_d;
  logic [dfr_pkg::GroupW-1:0] group_q, group_d;
  logic [AddrW-1:0]        rd_ptr_q, rd_ptr_d;

  logic                    out_valid_q, out_valid_d;
  logic [BW-1:0]           out_byte_q, out_byte_d;
  logic                    out_last_q, out_last_d;
  logic [dfr_pkg::LenW-1:0]   out_len_q, out_len_d;
  logic                    out_bcast_q, out_bcast_d;
  logic [dfr_pkg::GroupW-1:0] out_group_q, out_group_d;

  logic                    in_acc;
  logic                    buf_we;
  logic [BW-1:0]           rd_data;
  dfr_pkg::taps_t          taps;
  logic [BW-1:0]           cmp_a, cmp_b;
  logic                    cmp_eq, cmp_ge;
  logic                    out_free;
  logic                    rd_last;
  logic [1:0]              cnt_inc;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign buf_we   = in_acc && (wp_q < PosW'(FRAME_CAPACITY));
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign rd_last  = ((PosW'(rd_ptr_q) + PosW'(1)) == len_q);
  assign cnt_inc  = cnt_q + 2'd1;

  dfr_linebuf #(
    .Depth(FRAME_CAPACITY)
  ) u_linebuf (
    .clk_i  (clk_i),
    .we_i   (buf_we),
    .waddr_i(wp_q[AddrW-1:0]),
    .wdata_i(s_axis_tdata_i),
    .raddr_i(rd_ptr_q),
    .rdata_o(rd_data),
    .taps_o (taps)
  );

  // operand select for the shared comparator
  always_comb begin
    cmp_a = byte_q;
    cmp_b = delim_q;
    unique case (state_q)
      S_DELIM: begin
        cmp_a = byte_q;
        cmp_b = delim_q;
      end
      S_LEN: begin
        cmp_a = BW'(wp_q);
        cmp_b = dfr_pkg::MinFrameLen;
      end
      S_HEAD: begin
        cmp_a = taps.head;
        cmp_b = delim_q;
      end
      S_BLEN: begin
        cmp_a = BW'(len_q);
        cmp_b = dfr_pkg::BcastMinLen;
      end
      S_BA: begin
        cmp_a = taps.bcast_a;
        cmp_b = dfr_pkg::BcastValA;
      end
      S_BB: begin
        cmp_a = taps.bcast_b;
        cmp_b = dfr_pkg::BcastValB;
      end
      default: begin
        cmp_a = byte_q;
        cmp_b = delim_q;
      end
    endcase
  end

  dfr_cmp u_cmp (
    .a_i (cmp_a),
    .b_i (cmp_b),
    .eq_o(cmp_eq),
    .ge_o(cmp_ge)
  );

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    cnt_d       = cnt_q;
    byte_d      = byte_q;
    flag_d      = flag_q;
    len_d       = len_q;
    bcast_d     = bcast_q;
    group_d     = group_q;
    rd_ptr_d    = rd_ptr_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_len_d   = out_len_q;
    out_bcast_d = out_bcast_q;
    out_group_d = out_group_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (buf_we) begin
            wp_d    = wp_q + PosW'(1);
            byte_d  = s_axis_tdata_i;
            state_d = S_DELIM;
          end else begin
            // byte beyond capacity: drop the frame
            wp_d  = '0;
            cnt_d = '0;
          end
        end
      end
      S_DELIM: begin
        if (!cmp_eq) begin
          state_d = S_IDLE;
        end else if (cnt_inc < 2'd2) begin
          cnt_d   = cnt_inc;
          state_d = S_IDLE;
        end else begin
          len_d   = wp_q;
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        if (!cmp_ge) begin
          // short frame: the closing delimiter opens the next one
          cnt_d   = 2'd1;
          wp_d    = PosW'(1);
          state_d = S_IDLE;
        end else begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        wp_d  = '0;
        cnt_d = '0;
        if (cmp_eq) begin
          state_d = S_BLEN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_BLEN: begin
        flag_d  = cmp_ge;
        state_d = S_BA;
      end
      S_BA: begin
        flag_d  = flag_q && cmp_eq;
        state_d = S_BB;
      end
      S_BB: begin
        bcast_d  = flag_q && cmp_eq;
        group_d  = (flag_q && cmp_eq) ? {taps.group_h, taps.group_l} : '0;
        rd_ptr_d = '0;
        state_d  = S_EMITRD;
      end
      S_EMITRD: begin
        state_d = S_EMITLD;
      end
      S_EMITLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = rd_data;
          out_last_d  = rd_last;
          out_len_d   = dfr_pkg::LenW'(len_q);
          out_bcast_d = bcast_q;
          out_group_d = group_q;
          rd_ptr_d    = rd_ptr_q + AddrW'(1);
          state_d     = rd_last ? S_IDLE : S_EMITRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      cnt_q       <= '0;
      delim_q     <= dfr_pkg::DelimReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        delim_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    flag_q      <= flag_d;
    len_q       <= len_d;
    bcast_q     <= bcast_d;
    group_q     <= group_d;
    rd_ptr_q    <= rd_ptr_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_len_q   <= out_len_d;
    out_bcast_q <= out_bcast_d;
    out_group_q <= out_group_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_group_q, out_len_q, out_byte_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_bcast_q;

  a_wp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= PosW'(FRAME_CAPACITY))
    else $error("write position beyond capacity");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (cnt_q < 2'd2))
    else $error("delimiter count left at two");

  a_last_delim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tdata_o[7:0] == delim_q))
    else $error("frame does not end in the delimiter");

  a_group_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o[30:15] == '0))
    else $error("group address set on a non-broadcast frame");

  a_emit_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMITLD) |-> (len_q >= PosW'(dfr_pkg::MinFrameLen)))
    else $error("short frame being emitted");

endmodule

FILE: src/dfr_cmp.sv
// shared compare unit of the frame receiver: equality and unsigned greater-or-equal
// on two bytes; depends on dfr_pkg
module dfr_cmp (
  input  logic [dfr_pkg::ByteW-1:0] a_i,
  input  logic [dfr_pkg::ByteW-1:0] b_i,
  output logic                      eq_o,
  output logic                      ge_o
);

  assign eq_o = (a_i == b_i);
  assign ge_o = (a_i >= b_i);

endmodule

FILE: src/dfr_linebuf.sv
// line buffer of the frame receiver: one write port, one registered read port,
// plus copies of the few fixed positions the frame checks need; depends on dfr_pkg
module dfr_linebuf #(
  parameter int unsigned Depth = 64
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [$clog2(Depth)-1:0]  waddr_i,
  input  logic [dfr_pkg::ByteW-1:0] wdata_i,
  input  logic [$clog2(Depth)-1:0]  raddr_i,
  output logic [dfr_pkg::ByteW-1:0] rdata_o,
  output dfr_pkg::taps_t            taps_o
);

  localparam int unsigned AddrW = $clog2(Depth);

  logic [dfr_pkg::ByteW-1:0] mem [Depth];
  logic [dfr_pkg::ByteW-1:0] rdata_q;
  dfr_pkg::taps_t            taps_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  // shadow the checked positions as they are written
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      if (waddr_i == AddrW'(dfr_pkg::PosHead))   taps_q.head    <= wdata_i;
      if (waddr_i == AddrW'(dfr_pkg::PosBcastA)) taps_q.bcast_a <= wdata_i;
      if (waddr_i == AddrW'(dfr_pkg::PosBcastB)) taps_q.bcast_b <= wdata_i;
      if (waddr_i == AddrW'(dfr_pkg::PosGroupL)) taps_q.group_l <= wdata_i;
      if (waddr_i == AddrW'(dfr_pkg::PosGroupH)) taps_q.group_h <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;
  assign taps_o  = taps_q;

endmodule
